// ----- sv/tap_pkg.sv -----
// Shared types and constants for the triangle area accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tap_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int ENTRY_W = 20;
    localparam int ROW_W = 60;
    localparam int CFG_IDX_W = 3;
    localparam int P_W = 28;
    localparam int D_W = 29;
    localparam int CA_W = 57;
    localparam int CR_W = 56;
    localparam int HALF_W = 28;
    localparam int SQ_W = 112;
    localparam int ROOT_W = 56;
    localparam int REM_W = 58;
    localparam int ROOT_CNT_W = 6;
    localparam int AREA_W = 32;
    localparam int AREA_LSB = 17;
    localparam int SUM_W = 48;
    localparam int CNT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_LIMIT = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CART,
        ST_CART_END,
        ST_EDGE,
        ST_CROSS,
        ST_SQUARE,
        ST_SQ_END,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_CART,
        MOP_CROSS,
        MOP_SQUARE
    } mop_t;

    typedef struct packed {
        logic       store_corner;
        logic [1:0] corner_slot;
        logic       clear_sums;
        mop_t       mop;
        logic [1:0] k;
        logic [1:0] i;
        logic [1:0] j;
        logic       edge_load;
        logic       root_init;
        logic       root_step;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/tap_ctrl.sv -----
// Sequencer for the triangle area accumulator: corner intake and the
// multiply, square root and finish schedule. Depends on tap_pkg.
`default_nettype none

module tap_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              start_of_surface,
    output logic                   in_stall,
    input  wire tap_pkg::status_t  status,
    output tap_pkg::cmd_t          cmd
);

    tap_pkg::state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] ci_reg, ci_next;
    logic [1:0] cj_reg, cj_next;
    logic [1:0] ck_reg, ck_next;
    logic [tap_pkg::ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tap_pkg::ST_IDLE;
            phase_reg <= 2'd0;
            ci_reg <= 2'd0;
            cj_reg <= 2'd0;
            ck_reg <= 2'd0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ci_reg <= ci_next;
            cj_reg <= cj_next;
            ck_reg <= ck_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ci_next = ci_reg;
        cj_next = cj_reg;
        ck_next = ck_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        in_stall = 1'b1;
        slot = start_of_surface ? 2'd0 : phase_reg;
        case (state_reg)
            tap_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.store_corner = 1'b1;
                    cmd.corner_slot = slot;
                    cmd.clear_sums = start_of_surface;
                    if (slot == 2'd2)
                    begin
                        phase_next = 2'd0;
                        ci_next = 2'd0;
                        cj_next = 2'd0;
                        ck_next = 2'd0;
                        state_next = tap_pkg::ST_CART;
                    end
                    else
                    begin
                        phase_next = slot + 2'd1;
                    end
                end
            end
            tap_pkg::ST_CART:
            begin
                cmd.mop = tap_pkg::MOP_CART;
                cmd.k = ck_reg;
                cmd.i = ci_reg;
                cmd.j = cj_reg;
                if (cj_reg == 2'd2)
                begin
                    cj_next = 2'd0;
                    if (ci_reg == 2'd2)
                    begin
                        ci_next = 2'd0;
                        if (ck_reg == 2'd2)
                        begin
                            ck_next = 2'd0;
                            state_next = tap_pkg::ST_CART_END;
                        end
                        else
                        begin
                            ck_next = ck_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ci_next = ci_reg + 2'd1;
                    end
                end
                else
                begin
                    cj_next = cj_reg + 2'd1;
                end
            end
            tap_pkg::ST_CART_END:
            begin
                state_next = tap_pkg::ST_EDGE;
            end
            tap_pkg::ST_EDGE:
            begin
                cmd.edge_load = 1'b1;
                ci_next = 2'd0;
                cj_next = 2'd0;
                state_next = tap_pkg::ST_CROSS;
            end
            tap_pkg::ST_CROSS:
            begin
                cmd.mop = tap_pkg::MOP_CROSS;
                cmd.i = ci_reg;
                cmd.j = cj_reg;
                if (cj_reg == 2'd1)
                begin
                    cj_next = 2'd0;
                    if (ci_reg == 2'd2)
                    begin
                        ci_next = 2'd0;
                        state_next = tap_pkg::ST_SQUARE;
                    end
                    else
                    begin
                        ci_next = ci_reg + 2'd1;
                    end
                end
                else
                begin
                    cj_next = 2'd1;
                end
            end
            tap_pkg::ST_SQUARE:
            begin
                cmd.mop = tap_pkg::MOP_SQUARE;
                cmd.i = ci_reg;
                cmd.j = cj_reg;
                if (cj_reg == 2'd2)
                begin
                    cj_next = 2'd0;
                    if (ci_reg == 2'd2)
                    begin
                        ci_next = 2'd0;
                        state_next = tap_pkg::ST_SQ_END;
                    end
                    else
                    begin
                        ci_next = ci_reg + 2'd1;
                    end
                end
                else
                begin
                    cj_next = cj_reg + 2'd1;
                end
            end
            tap_pkg::ST_SQ_END:
            begin
                state_next = tap_pkg::ST_ROOT_INIT;
            end
            tap_pkg::ST_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                cnt_next = '0;
                state_next = tap_pkg::ST_ROOT;
            end
            tap_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == tap_pkg::ROOT_CNT_W'(tap_pkg::ROOT_W - 1))
                begin
                    state_next = tap_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tap_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = tap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tap_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/tap_dpath.sv -----
// Datapath of the triangle area accumulator: configuration registers, corner
// store, shared multiplier, square root unit, totals and result register.
// Depends on tap_pkg; driven by tap_ctrl.
`default_nettype none

module tap_dpath #(
    parameter int COORD_WIDTH = tap_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tap_pkg::cmd_t                       cmd,
    output tap_pkg::status_t                         status,
    input  wire logic signed [COORD_WIDTH-1:0]       corner_x,
    input  wire logic signed [COORD_WIDTH-1:0]       corner_y,
    input  wire logic signed [COORD_WIDTH-1:0]       corner_z,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tap_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tap_pkg::ROW_W-1:0]           cfg_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [tap_pkg::AREA_W-1:0]               triangle_area,
    output logic                                     accepted,
    output logic [tap_pkg::SUM_W-1:0]                total_area,
    output logic [tap_pkg::CNT_W-1:0]                triangle_count,
    output logic [tap_pkg::CNT_W-1:0]                rejected_count
);

    localparam int MW = (COORD_WIDTH > tap_pkg::D_W) ? COORD_WIDTH : tap_pkg::D_W;
    localparam int AW = COORD_WIDTH + 22;
    localparam int SH = COORD_WIDTH - 6;
    localparam logic [AW-1:0] CART_HALF = AW'(1) << (SH - 1);
    localparam int PROD_W = 2 * tap_pkg::HALF_W;
    localparam int OVF_LSB = tap_pkg::AREA_W + tap_pkg::AREA_LSB;

    logic [tap_pkg::ROW_W-1:0] row_reg [3];
    logic [tap_pkg::AREA_W-1:0] limit_reg;

    logic signed [COORD_WIDTH-1:0] corner_reg [3][3];
    logic signed [tap_pkg::P_W-1:0] p_reg [3][3];
    logic signed [tap_pkg::D_W-1:0] d1_reg [3];
    logic signed [tap_pkg::D_W-1:0] d2_reg [3];
    logic [tap_pkg::CR_W-1:0] cr_mag_reg [3];

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] prod_reg;
    tap_pkg::mop_t mop_reg;
    logic [1:0] k_reg, i_reg, j_reg;

    logic [tap_pkg::ROW_W-1:0] row_sel;
    logic signed [tap_pkg::ENTRY_W-1:0] entry;
    logic [1:0] u_idx, v_idx;
    logic [tap_pkg::HALF_W-1:0] part_hi, part_lo;

    logic signed [AW-1:0] cart_acc_reg, cart_sum, cart_rnd;
    logic signed [tap_pkg::CA_W-1:0] cross_acc_reg, cross_prod, cross_diff, cross_abs;
    logic [tap_pkg::SQ_W-1:0] sq_acc_reg, sq_term;

    logic [tap_pkg::SQ_W-1:0] rad_reg;
    logic [tap_pkg::ROOT_W-1:0] root_reg;
    logic [tap_pkg::REM_W-1:0] rem_reg;
    logic [tap_pkg::REM_W+1:0] rem_sh, trial, rem_diff;
    logic root_ge;

    logic ovf, ok;
    logic [tap_pkg::AREA_W-1:0] area;
    logic [tap_pkg::SUM_W:0] sum_add;
    logic [tap_pkg::SUM_W-1:0] sum_reg, sum_new;
    logic [tap_pkg::CNT_W-1:0] acc_cnt_reg, acc_cnt_new, rej_cnt_reg, rej_cnt_new;

    logic out_valid_reg;
    logic [tap_pkg::AREA_W-1:0] out_area_reg;
    logic out_ok_reg;
    logic [tap_pkg::SUM_W-1:0] out_total_reg;
    logic [tap_pkg::CNT_W-1:0] out_acc_reg, out_rej_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
            limit_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tap_pkg::REG_ROW_X: row_reg[0] <= cfg_data;
                tap_pkg::REG_ROW_Y: row_reg[1] <= cfg_data;
                tap_pkg::REG_ROW_Z: row_reg[2] <= cfg_data;
                tap_pkg::REG_AREA_LIMIT: limit_reg <= cfg_data[tap_pkg::AREA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_corner)
        begin
            corner_reg[cmd.corner_slot][0] <= corner_x;
            corner_reg[cmd.corner_slot][1] <= corner_y;
            corner_reg[cmd.corner_slot][2] <= corner_z;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        row_sel = row_reg[cmd.i];
        entry = row_sel[cmd.j*tap_pkg::ENTRY_W +: tap_pkg::ENTRY_W];
        case (cmd.i)
            2'd0:
            begin
                u_idx = 2'd1;
                v_idx = 2'd2;
            end
            2'd1:
            begin
                u_idx = 2'd2;
                v_idx = 2'd0;
            end
            default:
            begin
                u_idx = 2'd0;
                v_idx = 2'd1;
            end
        endcase
        part_hi = cr_mag_reg[cmd.i][tap_pkg::CR_W-1:tap_pkg::HALF_W];
        part_lo = cr_mag_reg[cmd.i][tap_pkg::HALF_W-1:0];
        case (cmd.mop)
            tap_pkg::MOP_CART:
            begin
                mul_a = MW'(entry);
                mul_b = MW'(corner_reg[cmd.k][cmd.j]);
            end
            tap_pkg::MOP_CROSS:
            begin
                if (cmd.j == 2'd0)
                begin
                    mul_a = MW'(d1_reg[u_idx]);
                    mul_b = MW'(d2_reg[v_idx]);
                end
                else
                begin
                    mul_a = MW'(d1_reg[v_idx]);
                    mul_b = MW'(d2_reg[u_idx]);
                end
            end
            tap_pkg::MOP_SQUARE:
            begin
                mul_a = (cmd.j == 2'd2) ? $signed(MW'(part_lo)) : $signed(MW'(part_hi));
                mul_b = (cmd.j == 2'd0) ? $signed(MW'(part_hi)) : $signed(MW'(part_lo));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mop_reg <= tap_pkg::MOP_NONE;
        end
        else
        begin
            mop_reg <= cmd.mop;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        k_reg <= cmd.k;
        i_reg <= cmd.i;
        j_reg <= cmd.j;
    end

    always_comb
    begin
        cart_sum = ((j_reg == 2'd0) ? AW'(0) : cart_acc_reg) + $signed(prod_reg[AW-1:0]);
        cart_rnd = cart_sum + $signed(CART_HALF);
        cross_prod = $signed(prod_reg[tap_pkg::CA_W-1:0]);
        cross_diff = cross_acc_reg - cross_prod;
        cross_abs = cross_diff[tap_pkg::CA_W-1] ? -cross_diff : cross_diff;
        case (j_reg)
            2'd0: sq_term = {prod_reg[PROD_W-1:0], {PROD_W{1'b0}}};
            2'd1: sq_term = tap_pkg::SQ_W'(prod_reg[PROD_W-1:0]) << (tap_pkg::HALF_W + 1);
            default: sq_term = tap_pkg::SQ_W'(prod_reg[PROD_W-1:0]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mop_reg == tap_pkg::MOP_CART)
        begin
            cart_acc_reg <= cart_sum;
            if (j_reg == 2'd2)
            begin
                p_reg[k_reg][i_reg] <= tap_pkg::P_W'(cart_rnd >>> SH);
            end
        end
        if (cmd.edge_load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                d1_reg[a] <= tap_pkg::D_W'(p_reg[1][a]) - tap_pkg::D_W'(p_reg[0][a]);
                d2_reg[a] <= tap_pkg::D_W'(p_reg[2][a]) - tap_pkg::D_W'(p_reg[0][a]);
            end
        end
        if (mop_reg == tap_pkg::MOP_CROSS)
        begin
            if (j_reg == 2'd0)
            begin
                cross_acc_reg <= cross_prod;
            end
            else
            begin
                cr_mag_reg[i_reg] <= cross_abs[tap_pkg::CR_W-1:0];
            end
        end
        if (cmd.edge_load)
        begin
            sq_acc_reg <= '0;
        end
        else if (mop_reg == tap_pkg::MOP_SQUARE)
        begin
            sq_acc_reg <= sq_acc_reg + sq_term;
        end
    end

    // Digit-by-digit square root, one result bit per cycle.
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[tap_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        root_ge = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_init)
        begin
            rad_reg <= sq_acc_reg;
            root_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg <= rad_reg << 2;
            rem_reg <= root_ge ? rem_diff[tap_pkg::REM_W-1:0] : rem_sh[tap_pkg::REM_W-1:0];
            root_reg <= {root_reg[tap_pkg::ROOT_W-2:0], root_ge};
        end
    end

    always_comb
    begin
        ovf = |root_reg[tap_pkg::ROOT_W-1:OVF_LSB];
        area = ovf ? '1 : root_reg[OVF_LSB-1:tap_pkg::AREA_LSB];
        ok = !ovf && (area < limit_reg);
        sum_add = {1'b0, sum_reg} + (tap_pkg::SUM_W + 1)'(area);
        sum_new = sum_reg;
        acc_cnt_new = acc_cnt_reg;
        rej_cnt_new = rej_cnt_reg;
        if (ok)
        begin
            sum_new = sum_add[tap_pkg::SUM_W] ? '1 : sum_add[tap_pkg::SUM_W-1:0];
            if (acc_cnt_reg != '1)
            begin
                acc_cnt_new = acc_cnt_reg + 1'b1;
            end
        end
        else if (rej_cnt_reg != '1)
        begin
            rej_cnt_new = rej_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            acc_cnt_reg <= '0;
            rej_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_sums)
            begin
                sum_reg <= '0;
                acc_cnt_reg <= '0;
                rej_cnt_reg <= '0;
            end
            else if (cmd.finish)
            begin
                sum_reg <= sum_new;
                acc_cnt_reg <= acc_cnt_new;
                rej_cnt_reg <= rej_cnt_new;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_area_reg <= area;
            out_ok_reg <= ok;
            out_total_reg <= sum_new;
            out_acc_reg <= acc_cnt_new;
            out_rej_reg <= rej_cnt_new;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign triangle_area = out_area_reg;
    assign accepted = out_ok_reg;
    assign total_area = out_total_reg;
    assign triangle_count = out_acc_reg;
    assign rejected_count = out_rej_reg;

endmodule

`default_nettype wire

// ----- sv/triangle_area_accumulator_top.sv -----
// Top level of the triangle area accumulator: joins tap_ctrl and tap_dpath.
// Depends on tap_pkg, tap_ctrl and tap_dpath.
//
// Corners arrive one per request; every third corner starts the triangle
// computation, during which in_stall is high. After its third corner, a
// triangle passes through the Cartesian mapping on the shared multiplier,
// the cross product, the squared length and the one-bit-per-cycle square
// root, with sequencing states between these steps.
// The result request sits in an output register, so the corners of the next
// triangle are accepted and its computation runs while it waits; only the
// final step stalls until the register is free. Configuration is written
// through a port that is always ready.
`default_nettype none

module triangle_area_accumulator_top #(
    parameter int COORD_WIDTH = tap_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]  corner_x,
    input  wire logic signed [COORD_WIDTH-1:0]  corner_y,
    input  wire logic signed [COORD_WIDTH-1:0]  corner_z,
    input  wire logic                           start_of_surface,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [tap_pkg::AREA_W-1:0]          triangle_area,
    output logic                                accepted,
    output logic [tap_pkg::SUM_W-1:0]           total_area,
    output logic [tap_pkg::CNT_W-1:0]           triangle_count,
    output logic [tap_pkg::CNT_W-1:0]           rejected_count,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tap_pkg::ROW_W-1:0]      cfg_data
);

    tap_pkg::cmd_t cmd;
    tap_pkg::status_t status;

    tap_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .start_of_surface (start_of_surface),
        .in_stall         (in_stall),
        .status           (status),
        .cmd              (cmd)
    );

    tap_dpath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .corner_x       (corner_x),
        .corner_y       (corner_y),
        .corner_z       (corner_z),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .triangle_area  (triangle_area),
        .accepted       (accepted),
        .total_area     (total_area),
        .triangle_count (triangle_count),
        .rejected_count (rejected_count)
    );

endmodule

`default_nettype wire

// ----- sv/tap_checker.sv -----
// Port-level checks for the triangle area accumulator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module tap_props (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] triangle_area,
    input wire logic        accepted,
    input wire logic [31:0] triangle_count,
    input wire logic [31:0] rejected_count
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    a_accept_not_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> triangle_area != 32'hFFFF_FFFF)
        else $error("saturated area reported as accepted");

    a_accept_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> triangle_count != 32'd0)
        else $error("accepted triangle not counted");

    a_reject_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> rejected_count != 32'd0)
        else $error("rejected triangle not counted");

endmodule

bind triangle_area_accumulator_top tap_props u_tap_props (.*);

`default_nettype wire
